>>> src/mfdc_pkg.sv
// Package for the MRU font descriptor cache: field structs, cell entry type,
// cell operation codes and base number helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfdc_pkg;

   // Sizes fixed by the field layout
   localparam int KEY_W           = 21;
   localparam int WIN_W           = 8;
   localparam int BASE_W          = 12;
   localparam int ENTRIES_DEFAULT = 10;
   localparam int MAX_REPORTS     = 10;

   // Base numbers are BASE_FIRST + BASE_STEP * k, k >= 1, taken modulo 4096
   localparam int BASE_FIRST = 1000;
   localparam int BASE_STEP  = 260;

   // Request function codes
   localparam logic FUNC_LOOKUP  = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   typedef struct packed {
      logic       func;
      logic [7:0] window_id;
      logic       italic;
      logic       bold;
      logic [7:0] font_size;
      logic [2:0] font_family;
   } req_type;

   typedef struct packed {
      logic [BASE_W-1:0] list_base;
      logic              hit;
      logic              build_needed;
      logic              evicted;
      logic [BASE_W-1:0] evicted_base;
      logic              last;
   } rsp_type;

   // One cached entry as held in a cell
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [BASE_W-1:0] base;
   } entry_type;

   // What a cell loads at the next edge
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PREV,
      OP_NEXT,
      OP_FRONT
   } cell_op_type;

   // Packed key: window, italic, bold, size, family
   function automatic logic [KEY_W-1:0] make_key(input req_type r);
      return {r.window_id, r.italic, r.bold, r.font_size, r.font_family};
   endfunction

   // Candidate base number for step k
   function automatic logic [BASE_W-1:0] base_cand(input int k);
      int s;
      s = BASE_FIRST + BASE_STEP * k;
      return s[BASE_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/mfdc_cell.sv
// One cell of the entry chain: holds a valid flag, key and base, loads from
// its neighbors or the front bus, and reports key, window and base matches.
// Depends on mfdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfdc_cell #(
   parameter int CANDS = mfdc_pkg::ENTRIES_DEFAULT + 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mfdc_pkg::cell_op_type        op,
   input  mfdc_pkg::entry_type          prev_entry,
   input  mfdc_pkg::entry_type          next_entry,
   input  mfdc_pkg::entry_type          front_entry,
   input  logic [mfdc_pkg::KEY_W-1:0]   req_key,
   output mfdc_pkg::entry_type          entry,
   output logic                         key_match,
   output logic                         win_match,
   output logic [CANDS-1:0]             used
);
   import mfdc_pkg::*;

   entry_type         entry_in;
   logic              valid_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [BASE_W-1:0] base_ff;

   assign entry = '{valid: valid_ff, key: key_ff, base: base_ff};

   // Next content select
   always_comb begin
      case (op)
         OP_PREV:  entry_in = prev_entry;
         OP_NEXT:  entry_in = next_entry;
         OP_FRONT: entry_in = front_entry;
         default:  entry_in = entry;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= entry_in.key;
      base_ff <= entry_in.base;
   end

   // Match flags, qualified by valid
   assign key_match = valid_ff && (key_ff == req_key);
   assign win_match = valid_ff &&
      (key_ff[KEY_W-1 -: WIN_W] == req_key[KEY_W-1 -: WIN_W]);

   // Which candidate bases this cell already holds
   for (genvar k = 0; k < CANDS; k++) begin : g_used
      assign used[k] = valid_ff && (base_ff == base_cand(k + 1));
   end

endmodule

`default_nettype wire

>>> src/mru_font_descriptor_cache_top.sv
// Top level of the MRU font descriptor cache: request latch, control FSM,
// response register and the chain of entry cells.
// Depends on mfdc_pkg and mfdc_cell.
`timescale 1ns / 1ps
`default_nettype none

// Fully associative font key cache kept in most-recently-used order in a
// chain of ENTRIES cells. After the transfer, a lookup compares the key
// against every cell, picks the base and shifts the chain; its one result
// is registered onto rsp_. A release, after the transfer, frees matching
// entries one at a time (front-most first, at most ten per request), with
// a result for each; a release that finds nothing ends with no result.
// Any step that would load the response register while it is still full
// waits for rsp_ready. One request is handled at a time; req_ready is high
// only while nothing is in progress. No clearing pass runs after reset.
module mru_font_descriptor_cache_top #(
   parameter int ENTRIES = mfdc_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mfdc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mfdc_pkg::rsp_type rsp_data
);
   import mfdc_pkg::*;

   localparam int CANDS  = ENTRIES + 1;
   localparam int NREP_W = $clog2(MAX_REPORTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_REL
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic [NREP_W-1:0]  nrep_ff;

   logic [KEY_W-1:0]   req_key;
   entry_type          ent [ENTRIES];
   cell_op_type        ops [ENTRIES];
   logic [CANDS-1:0]   used_cell [ENTRIES];
   logic [ENTRIES-1:0] key_match;
   logic [ENTRIES-1:0] win_match;
   entry_type          front_entry;
   entry_type          empty_entry;

   logic               hit;
   logic               full;
   logic [ENTRIES-1:0] shift_hit;
   logic [ENTRIES-1:0] shift_rel;
   logic [ENTRIES-1:0] first_oh;
   logic [ENTRIES-1:0] rest;
   logic [BASE_W-1:0]  hit_base;
   logic [BASE_W-1:0]  rel_base;
   logic [BASE_W-1:0]  free_base;
   logic [BASE_W-1:0]  front_base;
   logic [CANDS-1:0]   used_all;
   logic [CANDS-1:0]   unused;
   logic [CANDS-1:0]   pick;
   logic               out_free;
   logic               do_look;
   logic               do_rel;
   logic               rsp_load;
   logic               last_rel;

   assign req_key     = make_key(req_ff);
   assign empty_entry = '{valid: 1'b0, key: '0, base: '0};

   // Chain of cells
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      if (i == 0) begin : g_first
         assign prev_e = empty_entry;
      end else begin : g_mid
         assign prev_e = ent[i-1];
      end
      if (i == ENTRIES - 1) begin : g_last
         assign next_e = empty_entry;
      end else begin : g_inner
         assign next_e = ent[i+1];
      end
      mfdc_cell #(
         .CANDS(CANDS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (ops[i]),
         .prev_entry  (prev_e),
         .next_entry  (next_e),
         .front_entry (front_entry),
         .req_key     (req_key),
         .entry       (ent[i]),
         .key_match   (key_match[i]),
         .win_match   (win_match[i]),
         .used        (used_cell[i])
      );
   end

   // Lookup: hit position, hit base and the prefix of cells that shift
   always_comb begin
      logic below;
      below    = 1'b0;
      hit_base = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         below        = below | key_match[i];
         shift_hit[i] = below;
         if (key_match[i]) begin
            hit_base = hit_base | ent[i].base;
         end
      end
   end

   assign hit  = |key_match;
   assign full = ent[ENTRIES-1].valid;

   // Smallest candidate base not held by any valid cell
   always_comb begin
      used_all = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         used_all = used_all | used_cell[i];
      end
   end

   assign unused = ~used_all;
   assign pick   = unused & (~unused + CANDS'(1));

   always_comb begin
      free_base = '0;
      for (int k = 0; k < CANDS; k++) begin
         if (pick[k]) begin
            free_base = free_base | base_cand(k + 1);
         end
      end
   end

   always_comb begin
      if (hit) begin
         front_base = hit_base;
      end else if (full) begin
         front_base = ent[ENTRIES-1].base;
      end else begin
         front_base = free_base;
      end
   end

   assign front_entry = '{valid: 1'b1, key: req_key, base: front_base};

   // Release: front-most window match, cells from there on pull from behind
   assign first_oh = win_match & (~win_match + ENTRIES'(1));
   assign rest     = win_match & ~first_oh;

   always_comb begin
      logic seen;
      seen     = 1'b0;
      rel_base = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         seen         = seen | first_oh[i];
         shift_rel[i] = seen;
         if (first_oh[i]) begin
            rel_base = rel_base | ent[i].base;
         end
      end
   end

   assign last_rel = (rest == '0) || (nrep_ff == NREP_W'(MAX_REPORTS - 1));

   // Step enables
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign do_look  = (state_ff == ST_LOOK) && out_free;
   assign do_rel   = (state_ff == ST_REL) && (win_match != '0) && out_free;
   assign rsp_load = do_look || do_rel;

   // Cell operations
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (do_look) begin
            if (i == 0) begin
               ops[i] = OP_FRONT;
            end else if (!hit || shift_hit[i]) begin
               ops[i] = OP_PREV;
            end else begin
               ops[i] = OP_HOLD;
            end
         end else if (do_rel && shift_rel[i]) begin
            ops[i] = OP_NEXT;
         end else begin
            ops[i] = OP_HOLD;
         end
      end
   end

   // Control FSM and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         nrep_ff      <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  nrep_ff  <= '0;
                  state_ff <= (req_data.func == FUNC_RELEASE) ? ST_REL : ST_LOOK;
               end
            end
            ST_LOOK: begin
               if (out_free) begin
                  rsp_data_ff.list_base    <= front_base;
                  rsp_data_ff.hit          <= hit;
                  rsp_data_ff.build_needed <= !hit;
                  rsp_data_ff.evicted      <= !hit && full;
                  rsp_data_ff.evicted_base <= (!hit && full) ? front_base : '0;
                  rsp_data_ff.last         <= 1'b1;
                  state_ff                 <= ST_IDLE;
               end
            end
            ST_REL: begin
               if (win_match == '0) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_data_ff.list_base    <= rel_base;
                  rsp_data_ff.hit          <= 1'b0;
                  rsp_data_ff.build_needed <= 1'b0;
                  rsp_data_ff.evicted      <= 1'b1;
                  rsp_data_ff.evicted_base <= rel_base;
                  rsp_data_ff.last         <= last_rel;
                  nrep_ff                  <= nrep_ff + NREP_W'(1);
                  if (last_rel) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/mfdc_checker.sv
// Port-level checks for the MRU font descriptor cache, bound to the top.
// Depends on mfdc_pkg and mru_font_descriptor_cache_top.
`timescale 1ns / 1ps
`default_nettype none

module mfdc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mfdc_pkg::rsp_type rsp_data
);
   import mfdc_pkg::*;

   // A stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // One request at a time: no new transfer right after one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Evicted base mirrors list base, and is zero when nothing was evicted
   a_evict_base: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.evicted ? (rsp_data.evicted_base == rsp_data.list_base)
                                      : (rsp_data.evicted_base == '0)))
      else $error("evicted base inconsistent");

   // Lookup results are single and exclusive between hit and build
   a_lookup_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.hit || rsp_data.build_needed) |->
         rsp_data.last && (rsp_data.hit != rsp_data.build_needed) &&
         !(rsp_data.hit && rsp_data.evicted))
      else $error("lookup result malformed");

endmodule

bind mru_font_descriptor_cache_top mfdc_checker u_mfdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for mru_font_descriptor_cache_top: a scoreboard class
// mirrors the MRU entry order and the base allocation, and tasks drive the request channel.
// Depends on mfdc_pkg and the cache RTL.
`timescale 1ns / 1ps

module tb_top;
   import mfdc_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_PER_PHASE = 22;
   localparam int POOL_SIZE      = 14;

   // Mirror of the cache contents; builds the result stream expected for each request
   class font_cache_scoreboard;
      logic [KEY_W-1:0]  keys[ENTRIES_DEFAULT];
      logic [BASE_W-1:0] bases[ENTRIES_DEFAULT];
      int                count;
      rsp_type           pending[$];
      int                errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      // Smallest 1000 + 260*k (k >= 1) that no cached entry holds
      function logic [BASE_W-1:0] pick_free_base();
         logic [BASE_W-1:0] cand;
         int                sum;
         bit                taken;
         for (int k = 1; k <= ENTRIES_DEFAULT + 1; k++) begin
            sum   = 1000 + 260 * k;
            cand  = sum[BASE_W-1:0];
            taken = 1'b0;
            for (int i = 0; i < count; i++)
               if (bases[i] == cand) taken = 1'b1;
            if (!taken) return cand;
         end
         sum = 1000 + 260;
         return sum[BASE_W-1:0];
      endfunction

      // Called on each request transfer
      function void note_request(req_type r);
         logic [KEY_W-1:0]  k;
         logic [BASE_W-1:0] b;
         rsp_type           res;
         int                hit_at;
         int                n;
         int                i;
         k   = {r.window_id, r.italic, r.bold, r.font_size, r.font_family};
         res = '0;
         if (r.func == FUNC_LOOKUP) begin
            hit_at = -1;
            for (i = 0; i < count; i++)
               if (hit_at < 0 && keys[i] == k) hit_at = i;
            if (hit_at >= 0) begin
               // hit: move entry to the front
               b = bases[hit_at];
               for (i = hit_at; i > 0; i--) begin
                  keys[i]  = keys[i-1];
                  bases[i] = bases[i-1];
               end
               res.hit = 1'b1;
            end else begin
               // miss: reuse the last base when full, else allocate
               if (count == ENTRIES_DEFAULT) begin
                  b     = bases[ENTRIES_DEFAULT-1];
                  count = count - 1;
                  res.evicted      = 1'b1;
                  res.evicted_base = b;
               end else begin
                  b = pick_free_base();
               end
               for (i = count; i > 0; i--) begin
                  keys[i]  = keys[i-1];
                  bases[i] = bases[i-1];
               end
               count = count + 1;
               res.build_needed = 1'b1;
            end
            keys[0]       = k;
            bases[0]      = b;
            res.list_base = b;
            res.last      = 1'b1;
            pending.push_back(res);
         end else begin
            // release: drop entries of the window, front-most first, at most MAX_REPORTS
            n = 0;
            i = 0;
            while (i < count && n < MAX_REPORTS) begin
               if (keys[i][KEY_W-1 -: WIN_W] == r.window_id) begin
                  res              = '0;
                  res.list_base    = bases[i];
                  res.evicted      = 1'b1;
                  res.evicted_base = bases[i];
                  pending.push_back(res);
                  n = n + 1;
                  for (int j = i; j < count - 1; j++) begin
                     keys[j]  = keys[j+1];
                     bases[j] = bases[j+1];
                  end
                  count = count - 1;
               end else begin
                  i = i + 1;
               end
            end
            if (n > 0) begin
               res      = pending.pop_back();
               res.last = 1'b1;
               pending.push_back(res);
            end
         end
      endfunction

      // Called on each result transfer
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $error("unexpected result transfer: list_base %0d evicted_base %0d",
                   got.list_base, got.evicted_base);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.list_base !== want.list_base) begin
            $error("list_base: expected %0d, actual %0d", want.list_base, got.list_base);
            errors++;
         end
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
            errors++;
         end
         if (got.build_needed !== want.build_needed) begin
            $error("build_needed: expected %0d, actual %0d", want.build_needed,
                   got.build_needed);
            errors++;
         end
         if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
            errors++;
         end
         if (got.evicted_base !== want.evicted_base) begin
            $error("evicted_base: expected %0d, actual %0d", want.evicted_base,
                   got.evicted_base);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   font_cache_scoreboard sb = new();

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int quiet_cycles   = 0;

   req_type     key_pool[POOL_SIZE];
   logic [7:0]  pool_windows[3];

   mru_font_descriptor_cache_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Transfer monitor, scoreboard hookup and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   function automatic req_type font_request(logic f, logic [7:0] w, logic it, logic bo,
                                            logic [7:0] sz, logic [2:0] fam);
      req_type r;
      r.func        = f;
      r.window_id   = w;
      r.italic      = it;
      r.bold        = bo;
      r.font_size   = sz;
      r.font_family = fam;
      return r;
   endfunction

   // Distinct keys for the fill sequence, covering field extremes
   function automatic req_type fill_key(int i);
      logic [3:0] b;
      b = i[3:0];
      return font_request(FUNC_LOOKUP, b[0] ? 8'hFF : 8'h00, b[1], b[2],
                          b[3] ? 8'hFF : 8'h00, b[0] ? 3'd7 : 3'd0);
   endfunction

   // One request transfer, with an optional idle gap in front of it
   task automatic send_request(input req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold the sender off until every outstanding result has arrived;
   // the first edge lets the monitor note the last request transfer
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // New key pool over three windows so hits, evictions and releases are frequent
   task automatic refill_pool();
      for (int i = 0; i < 3; i++) pool_windows[i] = 8'($urandom_range(255));
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = font_request(FUNC_LOOKUP, pool_windows[$urandom_range(2)],
                                    1'($urandom_range(1)), 1'($urandom_range(1)),
                                    8'($urandom_range(255)), 3'($urandom_range(7)));
   endtask

   task automatic run_directed();
      send_request(font_request(FUNC_RELEASE, 8'd5, 1'b0, 1'b0, 8'd0, 3'd0)); // empty cache
      for (int i = 0; i < 10; i++) send_request(fill_key(i));                // fill to full
      send_request(fill_key(4));                                              // hit mid
      send_request(fill_key(4));                                              // hit front
      send_request(fill_key(0));                                              // hit last
      send_request(font_request(FUNC_LOOKUP, 8'h80, 1'b1, 1'b1, 8'h55, 3'd2)); // evict
      send_request(font_request(FUNC_LOOKUP, 8'h81, 1'b0, 1'b1, 8'hAA, 3'd5)); // evict
      send_request(font_request(FUNC_RELEASE, 8'hFF, 1'b1, 1'b1, 8'hFF, 3'd7)); // many freed
      send_request(font_request(FUNC_RELEASE, 8'h00, 1'b0, 1'b0, 8'h00, 3'd0));
      send_request(font_request(FUNC_LOOKUP, 8'h40, 1'b0, 1'b0, 8'h0C, 3'd1)); // reuse base
      send_request(font_request(FUNC_RELEASE, 8'h81, 1'b0, 1'b0, 8'h00, 3'd0)); // single
   endtask

   task automatic run_random(int n_items);
      req_type r;
      int      pick;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(99);
         if (pick < 70)
            r = key_pool[$urandom_range(1) ? $urandom_range(7) : $urandom_range(POOL_SIZE-1)];
         else if (pick < 85)
            r = font_request(FUNC_RELEASE, pool_windows[$urandom_range(2)],
                             1'($urandom_range(1)), 1'($urandom_range(1)),
                             8'($urandom_range(255)), 3'($urandom_range(7)));
         else
            r = req_type'($urandom);
         send_request(r);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no idling, directed cases first
      run_directed();
      wait_results_drained();
      refill_pool();
      run_random(RANDOM_PER_PHASE);
      wait_results_drained();

      // sender idling
      send_idle_pct = 67;
      refill_pool();
      run_random(RANDOM_PER_PHASE);
      wait_results_drained();

      // receiver stalling
      send_idle_pct  = 0;
      recv_stall_pct = 67;
      refill_pool();
      run_random(RANDOM_PER_PHASE);
      wait_results_drained();

      // light idling on both sides
      send_idle_pct  = 8;
      recv_stall_pct = 8;
      refill_pool();
      run_random(RANDOM_PER_PHASE);
      wait_results_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
src/mfdc_pkg.sv
src/mfdc_cell.sv
src/mru_font_descriptor_cache_top.sv
src/mfdc_checker.sv
tb/tb_top.sv
